/* hdl/mcoc_pkg.sv */
// Shared constants for the matrix chain order cost core.
package mcoc_pkg;

  localparam int COST_W = 40;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam int STATUS_W = 2;
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_SHORT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_LONG  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Widest triple product the saturation logic handles (three 16-bit factors).
  localparam int PROD_W = 48;

endpackage

/* hdl/mcoc_if.sv */
// Valid/ready channel interfaces for dimensions in and chain costs out.
interface mcoc_in_if #(parameter int DW = 10);
  logic          valid;
  logic          ready;
  logic [DW-1:0] dim_value;
  logic          last_dim;
  modport source (output valid, dim_value, last_dim, input ready);
  modport sink   (input valid, dim_value, last_dim, output ready);
endinterface

interface mcoc_out_if;
  logic                           valid;
  logic                           ready;
  logic [mcoc_pkg::COST_W-1:0]    min_cost;
  logic [mcoc_pkg::STATUS_W-1:0]  status;
  modport source (output valid, min_cost, status, input ready);
  modport sink   (input valid, min_cost, status, output ready);
endinterface

/* hdl/mcoc_queue.sv */
// Small register FIFO between the load front end and the table engine.
module mcoc_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0]              mem_r [mcoc_pkg::QUEUE_DEPTH];
  logic [mcoc_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [mcoc_pkg::QPTR_W:0]     count_r, count_nxt;

  assign full      = (count_r == (mcoc_pkg::QPTR_W+1)'(mcoc_pkg::QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + 1'b1;
    if (pop && !push) count_nxt = count_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= push_data;
  end

endmodule

/* hdl/mcoc_front.sv */
// Load front end: counts dimensions, flags overflow and tags chain ends.
module mcoc_front #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 10,
  parameter int AW           = 6,
  parameter int CW           = 6,
  parameter int EW           = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  mcoc_in_if.sink       in_ch,
  input  logic          q_full,
  output logic          q_push,
  output logic [EW-1:0] q_data
);

  localparam int DEPTH = MAX_MATRICES + 1;
  localparam int NW    = $clog2(DEPTH + 1);

  logic [NW-1:0]               dim_count_r, dim_count_nxt, cnt_now;
  logic                        overflowed_r, overflowed_nxt;
  logic                        store, ovf_now;
  logic [mcoc_pkg::STATUS_W-1:0] status;
  logic [CW-1:0]               n_mat;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    store   = (dim_count_r < NW'(DEPTH));
    ovf_now = overflowed_r || !store;
    cnt_now = dim_count_r + NW'(store);
    n_mat   = CW'(cnt_now - 1'b1);
    if (ovf_now)                 status = mcoc_pkg::ST_LONG;
    else if (cnt_now < NW'(2))   status = mcoc_pkg::ST_SHORT;
    else                         status = mcoc_pkg::ST_OK;

    dim_count_nxt  = dim_count_r;
    overflowed_nxt = overflowed_r;
    if (q_push) begin
      if (in_ch.last_dim) begin
        dim_count_nxt  = '0;
        overflowed_nxt = 1'b0;
      end else begin
        dim_count_nxt  = cnt_now;
        overflowed_nxt = ovf_now;
      end
    end
  end

  assign q_data = {store, dim_count_r[AW-1:0], in_ch.dim_value[DIM_BITS-1:0], in_ch.last_dim,
                   status, n_mat};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_count_r  <= '0;
      overflowed_r <= 1'b0;
    end else begin
      dim_count_r  <= dim_count_nxt;
      overflowed_r <= overflowed_nxt;
    end
  end

endmodule

/* hdl/mcoc_back.sv */
// Table engine: stores dimensions, fills the interval cost table, emits the result.
module mcoc_back #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 10,
  parameter int AW           = 6,
  parameter int CW           = 6,
  parameter int EW           = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  logic [EW-1:0] q_data,
  output logic          q_pop,
  mcoc_out_if.source    out_ch
);

  localparam int IW    = (MAX_MATRICES > 1) ? $clog2(MAX_MATRICES) : 1;
  localparam int DEPTH = MAX_MATRICES + 1;
  localparam int CD    = 1 << (2 * IW);
  localparam int CWD   = mcoc_pkg::COST_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_IVL  = 3'd1;
  localparam logic [2:0] S_LOAD = 3'd2;
  localparam logic [2:0] S_RD   = 3'd3;
  localparam logic [2:0] S_MUL1 = 3'd4;
  localparam logic [2:0] S_MUL2 = 3'd5;
  localparam logic [2:0] S_CMP  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  // Queue entry fields.
  logic                          e_store, e_last;
  logic [AW-1:0]                 e_addr;
  logic [DIM_BITS-1:0]           e_dim;
  logic [mcoc_pkg::STATUS_W-1:0] e_status;
  logic [CW-1:0]                 e_n;

  assign {e_store, e_addr, e_dim, e_last, e_status, e_n} = q_data;

  logic [2:0]          state_r, state_nxt;
  logic [IW-1:0]       i_r, i_nxt, k_r, k_nxt, where_r, where_nxt;
  logic [CW-1:0]       len_r, len_nxt, n_r, n_nxt;
  logic [DIM_BITS-1:0] di_r, dj_r;
  logic [2*DIM_BITS-1:0] p1_r;
  logic [CWD-1:0]      sum_r, trip_r, best_r, best_nxt;
  logic [CWD-1:0]      cost_r, cost_nxt;
  logic [mcoc_pkg::STATUS_W-1:0] status_r, status_nxt;

  // Memories.
  logic [DIM_BITS-1:0] dims_mem [DEPTH];
  logic [CWD-1:0]      cost_mem [CD];
  logic [IW-1:0]       split_mem [CD];
  logic [DIM_BITS-1:0] dim_a_q, dim_b_q;
  logic [CWD-1:0]      ca_q, cb_q;
  logic [AW-1:0]       dim_a_addr, dim_b_addr;

  // Interval indexes.
  logic [CW:0]   ilen;
  logic [IW-1:0] j_w, kp1;
  logic          k_first, k_last;

  assign ilen    = (CW+1)'(i_r) + (CW+1)'(len_r);
  assign j_w     = IW'(ilen - 1'b1);
  assign kp1     = k_r + 1'b1;
  assign k_first = (k_r == i_r);
  assign k_last  = (kp1 == j_w);

  assign dim_a_addr = (state_r == S_IVL) ? AW'(i_r) : AW'(kp1);
  assign dim_b_addr = AW'(ilen);

  // Arithmetic per split point.
  logic [CWD-1:0]   left_c, right_c, q_w;
  logic [CWD:0]     sum_w, qsum_w;
  logic [3*DIM_BITS-1:0] prod_w;
  logic [mcoc_pkg::PROD_W-1:0] prod48;
  logic             take;

  always_comb begin
    left_c  = k_first ? '0 : ca_q;
    right_c = k_last  ? '0 : cb_q;
    sum_w   = (CWD+1)'(left_c) + (CWD+1)'(right_c);
    prod_w  = {{DIM_BITS{1'b0}}, p1_r} * {{(2*DIM_BITS){1'b0}}, dj_r};
    prod48  = mcoc_pkg::PROD_W'(prod_w);
    qsum_w  = (CWD+1)'(sum_r) + (CWD+1)'(trip_r);
    q_w     = qsum_w[CWD] ? mcoc_pkg::COST_MAX : qsum_w[CWD-1:0];
    take    = k_first || (q_w < best_r);
  end

  assign q_pop = q_valid && (state_r == S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    i_nxt      = i_r;
    k_nxt      = k_r;
    len_nxt    = len_r;
    n_nxt      = n_r;
    best_nxt   = best_r;
    where_nxt  = where_r;
    cost_nxt   = cost_r;
    status_nxt = status_r;
    unique case (state_r)
      S_IDLE: begin
        if (q_pop && e_last) begin
          n_nxt      = e_n;
          status_nxt = e_status;
          cost_nxt   = '0;
          i_nxt      = '0;
          len_nxt    = CW'(2);
          if (e_status == mcoc_pkg::ST_OK && e_n != CW'(1)) state_nxt = S_IVL;
          else                                              state_nxt = S_OUT;
        end
      end
      S_IVL:  state_nxt = S_LOAD;
      S_LOAD: begin
        k_nxt     = i_r;
        state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_CMP;
      S_CMP: begin
        if (take) begin
          best_nxt  = q_w;
          where_nxt = k_r;
        end
        if (k_last) begin
          // Interval done: move to the next start, the next chain length, or the result.
          if (ilen < (CW+1)'(n_r)) begin
            i_nxt     = i_r + 1'b1;
            state_nxt = S_IVL;
          end else if (len_r < n_r) begin
            len_nxt   = len_r + 1'b1;
            i_nxt     = '0;
            state_nxt = S_IVL;
          end else begin
            cost_nxt  = take ? q_w : best_r;
            state_nxt = S_OUT;
          end
        end else begin
          k_nxt     = kp1;
          state_nxt = S_RD;
        end
      end
      S_OUT: if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r      <= i_nxt;
    k_r      <= k_nxt;
    len_r    <= len_nxt;
    n_r      <= n_nxt;
    best_r   <= best_nxt;
    where_r  <= where_nxt;
    cost_r   <= cost_nxt;
    status_r <= status_nxt;
    if (state_r == S_LOAD) begin
      di_r <= dim_a_q;
      dj_r <= dim_b_q;
    end
    if (state_r == S_MUL1) begin
      p1_r  <= {{DIM_BITS{1'b0}}, di_r} * {{DIM_BITS{1'b0}}, dim_a_q};
      sum_r <= sum_w[CWD] ? mcoc_pkg::COST_MAX : sum_w[CWD-1:0];
    end
    if (state_r == S_MUL2) begin
      trip_r <= (|prod48[mcoc_pkg::PROD_W-1:CWD]) ? mcoc_pkg::COST_MAX : prod48[CWD-1:0];
    end
  end

  // Dimension store: write on load, two registered read ports.
  always_ff @(posedge clk) begin
    if (q_pop && e_store) dims_mem[e_addr] <= e_dim;
    dim_a_q <= dims_mem[dim_a_addr];
    dim_b_q <= dims_mem[dim_b_addr];
  end

  // Cost and split tables: one write port; two registered cost-table read ports.
  always_ff @(posedge clk) begin
    if (state_r == S_CMP && k_last) begin
      cost_mem[{i_r, j_w}]  <= take ? q_w : best_r;
      split_mem[{i_r, j_w}] <= take ? k_r : where_r;
    end
    ca_q <= cost_mem[{i_r, k_r}];
    cb_q <= cost_mem[{kp1, j_w}];
  end

  assign out_ch.valid    = (state_r == S_OUT);
  assign out_ch.min_cost = cost_r;
  assign out_ch.status   = status_r;

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.status != mcoc_pkg::ST_OK |-> out_ch.min_cost == '0)
    else $error("error result carries nonzero cost");

  a_split_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> k_r < j_w && ilen <= (CW+1)'(n_r))
    else $error("split point outside interval");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_OUT && !out_ch.ready |=> state_r == S_OUT && $stable(cost_r))
    else $error("result changed while stalled");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE)
    else $error("queue popped while busy");

endmodule

/* hdl/matrix_chain_order_cost_core.sv */
// Top level of the matrix chain order cost core.
//
// Usage: send the dimensions p0..pn of a chain on in_ch, one per transaction,
// with last_dim set on pn. Each chain gives one transaction on out_ch:
// min_cost with status OK, or cost 0 with status 1 (fewer than two
// dimensions) or status 2 (more than MAX_MATRICES+1 dimensions).
// Loading: one dimension per cycle through a four-entry queue; the front end
// keeps taking dimensions of the next chain while the engine works, until
// the queue fills.
// After the last dimension, the single cost-table engine fills the table
// and visits every split point in four steps (read, first multiply,
// second multiply, compare).
// Reset clears the load count, the overflow flag, the queue and the engine
// state; the tables need no clearing, as every entry is written before read.
// A stalled out_ch holds the result; the engine then takes no new entries and
// in_ch stalls once the queue is full.
module matrix_chain_order_cost_core #(
  parameter int MAX_MATRICES = 32,
  parameter int DIM_BITS     = 10
) (
  input logic        clk,
  input logic        rst_n,
  mcoc_in_if.sink    in_ch,
  mcoc_out_if.source out_ch
);

  // Address and count widths follow the store depth.
  localparam int AW = $clog2(MAX_MATRICES + 1);
  localparam int CW = $clog2(MAX_MATRICES + 1);
  localparam int EW = 1 + AW + DIM_BITS + 1 + mcoc_pkg::STATUS_W + CW;

  logic          q_push, q_pop, q_full, q_valid;
  logic [EW-1:0] q_wdata, q_rdata;

  // Classify each dimension and tag chain ends.
  mcoc_front #(
    .MAX_MATRICES(MAX_MATRICES), .DIM_BITS(DIM_BITS), .AW(AW), .CW(CW), .EW(EW)
  ) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .q_full(q_full), .q_push(q_push), .q_data(q_wdata)
  );

  // Decouple loading from table filling.
  mcoc_queue #(.WIDTH(EW)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(q_push), .push_data(q_wdata), .full(q_full),
    .pop(q_pop), .not_empty(q_valid), .pop_data(q_rdata)
  );

  // Store dimensions, fill the table, present the result.
  mcoc_back #(
    .MAX_MATRICES(MAX_MATRICES), .DIM_BITS(DIM_BITS), .AW(AW), .CW(CW), .EW(EW)
  ) u_back (
    .clk(clk), .rst_n(rst_n),
    .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop), .out_ch(out_ch)
  );

endmodule

/* tb/sv/tb_mcoc_pkg.sv */
// Chain size constants shared by the matrix chain order cost testbench.
package tb_mcoc_pkg;

  localparam int TB_MAX_MATRICES = 32;
  localparam int TB_DIM_DEPTH    = TB_MAX_MATRICES + 1;

endpackage

/* tb/sv/tb_mcoc_ifs.sv */
// Clocking-free helper interface: a plain cycle counter for the testbench.
interface tb_mcoc_cycle_if (input logic clk);
  int unsigned cycles = 0;
  always @(posedge clk) cycles <= cycles + 1;
endinterface

/* tb/sv/tb_matrix_chain_order_cost_core.sv */
// Testbench for matrix_chain_order_cost_core: random and directed chains vs a DP predictor.
module tb_matrix_chain_order_cost_core;

  typedef struct packed {
    logic [mcoc_pkg::COST_W-1:0]   cost;
    logic [mcoc_pkg::STATUS_W-1:0] status;
  } chain_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  mcoc_in_if #(.DW(10)) in_ch ();
  mcoc_out_if           out_ch ();
  tb_mcoc_cycle_if      cyc (.clk(clk));

  matrix_chain_order_cost_core uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source)
  );

  // Predictor state: the dimensions of the chain being loaded.
  logic [9:0]    dims_q [tb_mcoc_pkg::TB_DIM_DEPTH];
  int            dims_cnt = 0;
  bit            dims_over = 0;
  chain_result_t pending_costs [$];
  int            fail_count = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  int            hold_off_cycles = 0;
  bit            stim_done = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.dim_value = '0;
    in_ch.last_dim = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Interval DP over the stored dimensions; the first minimum wins.
  function automatic logic [mcoc_pkg::COST_W-1:0] chain_min_cost(int n);
    logic [mcoc_pkg::COST_W-1:0] tbl [tb_mcoc_pkg::TB_MAX_MATRICES]
                                     [tb_mcoc_pkg::TB_MAX_MATRICES];
    logic [63:0] best, q, p;
    int j;
    for (int i = 0; i < n; i++) tbl[i][i] = '0;
    for (int len = 2; len <= n; len++) begin
      for (int i = 0; i + len <= n; i++) begin
        j = i + len - 1;
        best = '1;
        for (int k = i; k < j; k++) begin
          p = 64'(dims_q[i]) * 64'(dims_q[k+1]) * 64'(dims_q[j+1]);
          if (p > 64'(mcoc_pkg::COST_MAX)) p = 64'(mcoc_pkg::COST_MAX);
          q = 64'(tbl[i][k]) + 64'(tbl[k+1][j]);
          if (q > 64'(mcoc_pkg::COST_MAX)) q = 64'(mcoc_pkg::COST_MAX);
          q = q + p;
          if (q > 64'(mcoc_pkg::COST_MAX)) q = 64'(mcoc_pkg::COST_MAX);
          if (q < best) best = q;
        end
        tbl[i][j] = best[mcoc_pkg::COST_W-1:0];
      end
    end
    return tbl[0][n-1];
  endfunction

  // Update the predictor for one accepted dimension.
  function automatic void predict_dim(logic [9:0] d, logic last);
    chain_result_t r;
    if (dims_cnt < tb_mcoc_pkg::TB_DIM_DEPTH) begin
      dims_q[dims_cnt] = d;
      dims_cnt++;
    end else begin
      dims_over = 1;
    end
    if (!last) return;
    r.cost = '0;
    if (dims_over) r.status = mcoc_pkg::ST_LONG;
    else if (dims_cnt < 2) r.status = mcoc_pkg::ST_SHORT;
    else begin
      r.status = mcoc_pkg::ST_OK;
      r.cost = chain_min_cost(dims_cnt - 1);
    end
    pending_costs.push_back(r);
    dims_cnt = 0;
    dims_over = 0;
  endfunction

  // Send one dimension; idle before it at the current rate.
  // Ready is sampled mid-cycle, so it is the value seen at the next edge.
  task automatic send_dim(input logic [9:0] d, input logic last);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.dim_value <= d;
    in_ch.last_dim <= last;
    forever begin
      @(negedge clk);
      rdy = in_ch.ready;
      @(posedge clk);
      if (rdy) break;
    end
    predict_dim(d, last);
  endtask

  task automatic send_chain(input int n_dims, input int max_dim);
    for (int i = 0; i < n_dims; i++)
      send_dim(10'($urandom_range(max_dim)), i == n_dims - 1);
  endtask

  // Drain: drop valid, wait until every expected cost has come back, then a quiet tail.
  task automatic drain_costs();
    in_ch.valid <= 1'b0;
    while (pending_costs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  // Receiver: stall at random, or hold off for a long stretch on request.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_off_cycles > 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Check each cost transaction against the oldest expectation.
  always @(posedge clk) begin
    chain_result_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_costs.size() == 0) begin
        $display("%0t: unexpected result cost=%0d status=%0d", $time,
                 out_ch.min_cost, out_ch.status);
        fail_count++;
      end else begin
        exp_r = pending_costs.pop_front();
        if (exp_r.cost !== out_ch.min_cost) begin
          $display("%0t: min_cost expected %0d actual %0d", $time, exp_r.cost,
                   out_ch.min_cost);
          fail_count++;
        end
        if (exp_r.status !== out_ch.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status,
                   out_ch.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on the cycle count.
  always @(posedge clk) begin
    if (cyc.cycles > 3000000) begin
      $display("[matrix_chain_order_cost_core] ERROR");
      $finish;
    end
  end

  task automatic test_directed();
    send_dim(10'd5, 1'b1);                     // one dimension only
    send_dim(10'd1023, 1'b0); send_dim(10'd1023, 1'b1);  // single matrix
    send_dim(10'd10, 1'b0); send_dim(10'd20, 1'b0);
    send_dim(10'd30, 1'b1);
    send_dim(10'd0, 1'b0); send_dim(10'd7, 1'b0);        // zero dimension
    send_dim(10'd9, 1'b0); send_dim(10'd3, 1'b1);
    for (int i = 0; i < 4; i++) send_dim(10'd1023, i == 3);
    send_dim(10'd1, 1'b0); send_dim(10'd1022, 1'b0);
    send_dim(10'd512, 1'b0); send_dim(10'd341, 1'b1);
    drain_costs();
  endtask

  task automatic test_extreme_lengths();
    send_chain(tb_mcoc_pkg::TB_DIM_DEPTH, 1023);      // full store, 32 matrices
    for (int i = 0; i < tb_mcoc_pkg::TB_DIM_DEPTH; i++)
      send_dim(10'd1023, i == tb_mcoc_pkg::TB_DIM_DEPTH - 1);
    send_chain(tb_mcoc_pkg::TB_DIM_DEPTH + 1, 1023);  // one too many
    send_chain(tb_mcoc_pkg::TB_DIM_DEPTH + 5, 1023);
    drain_costs();
  endtask

  task automatic test_random_phase(input int idle, input int stall, input int items);
    int sent;
    int len;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    sent = 0;
    while (sent < items) begin
      case ($urandom_range(19))
        0: len = 1;
        1: len = tb_mcoc_pkg::TB_DIM_DEPTH + $urandom_range(3);
        2: len = $urandom_range(20, tb_mcoc_pkg::TB_DIM_DEPTH);
        default: len = $urandom_range(2, 8);
      endcase
      send_chain(len, ($urandom_range(3) == 0) ? 1023 : 15);
      sent += len;
    end
    drain_costs();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off_cycles = 400;
    for (int c = 0; c < 12; c++) send_chain($urandom_range(1, 4), 1023);
    drain_costs();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_extreme_lengths();
    test_random_phase(0, 0, 420);
    test_random_phase(54, 0, 420);
    test_random_phase(0, 54, 420);
    test_random_phase(32, 32, 420);
    test_backpressure();
    if (fail_count == 0) begin
      $display("[matrix_chain_order_cost_core] OK");
    end else begin
      $display("[matrix_chain_order_cost_core] ERROR");
    end
    $finish;
  end

endmodule
